// ===== src/les_pkg.sv =====
// Shared types and constants for the leader election step block.
// No dependencies; used by les_step and leader_election_step_core.
`default_nettype none
package les_pkg;

  localparam int MaxNodes = 16;
  localparam logic [4:0] CountMax = 5'd31;

  typedef enum logic [2:0] {
    ModeHeartbeat = 3'd0,
    ModeVoteReq   = 3'd1,
    ModeVoteResp  = 3'd2,
    ModeTimeout   = 3'd3,
    ModeStart     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    RoleFollower  = 2'd0,
    RoleCandidate = 2'd1,
    RoleLeader    = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    CfgSelfId       = 2'd0,
    CfgClusterSize  = 2'd1,
    CfgRemotePeers  = 2'd2,
    CfgStartAsLeader = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] self_id;
    logic [4:0] cluster_size;
    logic [3:0] remote_peers;
    logic       start_as_leader;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] msg_term;
    logic [3:0]  from_node;
    logic [63:0] cand_lsn;
    logic [63:0] local_lsn;
    logic        granted;
  } event_t;

  typedef struct packed {
    role_e       node_role;
    logic [63:0] term;
    logic [3:0]  vote_holder;
    logic        vote_holder_valid;
    logic [3:0]  leader;
    logic        leader_valid;
    logic [4:0]  vote_count;
  } state_t;

  typedef struct packed {
    role_e       role;
    logic [63:0] term_now;
    logic [3:0]  leader_idx;
    logic        leader_known;
    logic        vote_granted;
    logic        became_leader;
    logic        stepped_down;
    logic        persist_write;
    logic [3:0]  persist_voted_id;
    logic        persist_voted_valid;
    logic        send_heartbeat;
    logic        send_vote_req;
  } result_t;

endpackage
`default_nettype wire

// ===== src/les_step.sv =====
// Combinational event handler: next node state and result for one event.
// Depends on les_pkg.
`default_nettype none
module les_step (
  input  wire les_pkg::cfg_t    cfg_i,
  input  wire les_pkg::state_t  state_i,
  input  wire les_pkg::event_t  ev_i,
  output les_pkg::state_t  state_o,
  output les_pkg::result_t res_o
);

  logic [4:0] n_eff;
  logic [4:0] quorum;

  always_comb begin
    if (cfg_i.cluster_size == 5'd0) begin
      n_eff = 5'd1;
    end else if (cfg_i.cluster_size > 5'(les_pkg::MaxNodes)) begin
      n_eff = 5'(les_pkg::MaxNodes);
    end else begin
      n_eff = cfg_i.cluster_size;
    end
  end

  assign quorum = 5'(({1'b0, n_eff} + 6'd1) >> 1);

  always_comb begin
    les_pkg::state_t  st;
    les_pkg::result_t r;
    logic             peers;
    st    = state_i;
    r     = '0;
    peers = (cfg_i.remote_peers != 4'd0);

    unique case (ev_i.mode)
      les_pkg::ModeHeartbeat: begin
        if (ev_i.msg_term > st.term) begin
          st.term              = ev_i.msg_term;
          st.vote_holder_valid = 1'b0;
          st.vote_holder       = 4'd0;
          r.persist_write      = 1'b1;
          if (st.node_role != les_pkg::RoleFollower) begin
            st.node_role   = les_pkg::RoleFollower;
            r.stepped_down = 1'b1;
          end
          st.leader       = ev_i.from_node;
          st.leader_valid = 1'b1;
        end else if (ev_i.msg_term == st.term) begin
          if (st.node_role == les_pkg::RoleCandidate) begin
            st.node_role    = les_pkg::RoleFollower;
            r.stepped_down  = 1'b1;
            st.leader       = ev_i.from_node;
            st.leader_valid = 1'b1;
          end else if (st.node_role == les_pkg::RoleFollower) begin
            st.leader       = ev_i.from_node;
            st.leader_valid = 1'b1;
          end else if (ev_i.from_node != cfg_i.self_id) begin
            // another leader at our term: yield
            st.node_role    = les_pkg::RoleFollower;
            r.stepped_down  = 1'b1;
            st.leader       = ev_i.from_node;
            st.leader_valid = 1'b1;
            r.persist_write = (st.term != 64'd0);
          end
        end
      end
      les_pkg::ModeVoteReq: begin
        if (ev_i.msg_term > st.term) begin
          st.term              = ev_i.msg_term;
          st.vote_holder_valid = 1'b0;
          st.vote_holder       = 4'd0;
          if (st.node_role != les_pkg::RoleFollower) begin
            st.node_role   = les_pkg::RoleFollower;
            r.stepped_down = 1'b1;
          end
        end
        if (ev_i.msg_term >= st.term && ev_i.cand_lsn >= ev_i.local_lsn &&
            (!st.vote_holder_valid || st.vote_holder == ev_i.from_node)) begin
          r.vote_granted        = 1'b1;
          st.vote_holder        = ev_i.from_node;
          st.vote_holder_valid  = 1'b1;
          r.persist_write       = 1'b1;
          r.persist_voted_id    = ev_i.from_node;
          r.persist_voted_valid = 1'b1;
        end
      end
      les_pkg::ModeVoteResp: begin
        if (ev_i.msg_term > st.term) begin
          st.term              = ev_i.msg_term;
          st.vote_holder_valid = 1'b0;
          st.vote_holder       = 4'd0;
          st.node_role         = les_pkg::RoleFollower;
          st.leader_valid      = 1'b0;
          st.leader            = 4'd0;
        end
        if (st.node_role == les_pkg::RoleCandidate && ev_i.msg_term >= st.term &&
            ev_i.granted) begin
          if (st.vote_count < les_pkg::CountMax) begin
            st.vote_count = st.vote_count + 5'd1;
          end
          if (st.vote_count >= quorum) begin
            st.node_role      = les_pkg::RoleLeader;
            st.leader         = cfg_i.self_id;
            st.leader_valid   = 1'b1;
            st.vote_count     = 5'd0;
            r.send_heartbeat  = peers;
            r.became_leader   = 1'b1;
          end
        end
      end
      les_pkg::ModeTimeout: begin
        if (st.node_role == les_pkg::RoleLeader) begin
          r.send_heartbeat = peers;
        end else begin
          if (st.term != '1) begin
            st.term = st.term + 64'd1;
          end
          st.vote_holder        = cfg_i.self_id;
          st.vote_holder_valid  = 1'b1;
          st.vote_count         = 5'd1;
          st.node_role          = les_pkg::RoleCandidate;
          r.persist_write       = 1'b1;
          r.persist_voted_id    = cfg_i.self_id;
          r.persist_voted_valid = 1'b1;
          r.send_vote_req       = peers;
          // single-node quorum: own vote suffices
          if (quorum == 5'd1) begin
            st.node_role     = les_pkg::RoleLeader;
            st.leader        = cfg_i.self_id;
            st.leader_valid  = 1'b1;
            st.vote_count    = 5'd0;
            r.send_heartbeat = peers;
            r.became_leader  = 1'b1;
          end
        end
      end
      les_pkg::ModeStart: begin
        if (cfg_i.start_as_leader) begin
          st.node_role    = les_pkg::RoleLeader;
          if (st.term == 64'd0) begin
            st.term = 64'd1;
          end
          st.leader       = cfg_i.self_id;
          st.leader_valid = 1'b1;
        end
      end
      default: begin
        // unknown event codes leave the state alone
      end
    endcase

    r.role         = st.node_role;
    r.term_now     = st.term;
    r.leader_idx   = st.leader_valid ? st.leader : 4'd0;
    r.leader_known = st.leader_valid;

    state_o = st;
    res_o   = r;
  end

endmodule
`default_nettype wire

// ===== src/leader_election_step_core.sv =====
// Top level of the leader election step block: request and result registers,
// node state, configuration registers. Depends on les_pkg and les_step.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one event request:
//    heartbeat, vote request, vote response, timeout or start.
//  - Output channel (out_valid_o / out_ready_i) returns exactly one result
//    per request, in order.
//  - An accepted request waits in the request register, then moves to the
//    result register when the result stage is free. Throughput: one request
//    per cycle while out_ready_i stays high. Request register, event logic
//    and result register form a two-stage path; the node state updates as a
//    request enters the result register, so the next sees it with no bubble.
//  - Receiver stall: the result register holds; the request register still
//    takes one more request, then in_ready_o drops until the result drains.
//  - Reset (rst_ni low, async): follower, term 0, no vote, no leader, count 0;
//    configuration returns to self_id 0, cluster_size 1, remote_peers 0,
//    start_as_leader 0. No clearing pass; requests are taken right away.
//  - Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i at the
//    clock edge; write only while no request is in flight.
`default_nettype none
module leader_election_step_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [4:0]  cfg_wdata_i,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [63:0] msg_term_i,
  input  wire logic [3:0]  from_node_i,
  input  wire logic [63:0] cand_lsn_i,
  input  wire logic [63:0] local_lsn_i,
  input  wire logic        granted_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       role_o,
  output logic [63:0]      term_now_o,
  output logic [3:0]       leader_idx_o,
  output logic             leader_known_o,
  output logic             vote_granted_o,
  output logic             became_leader_o,
  output logic             stepped_down_o,
  output logic             persist_write_o,
  output logic [3:0]       persist_voted_id_o,
  output logic             persist_voted_valid_o,
  output logic             send_heartbeat_o,
  output logic             send_vote_req_o
);

  les_pkg::cfg_t    cfg_q;
  les_pkg::event_t  ev_q;
  logic             ev_valid_q;
  les_pkg::state_t  state_q, state_d;
  les_pkg::result_t res_q, res_d;
  logic             out_valid_q;
  logic             advance;

  // result stage frees up when empty or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !ev_valid_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.self_id         <= 4'd0;
      cfg_q.cluster_size    <= 5'd1;
      cfg_q.remote_peers    <= 4'd0;
      cfg_q.start_as_leader <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (les_pkg::cfg_idx_e'(cfg_addr_i))
        les_pkg::CfgSelfId:        cfg_q.self_id         <= cfg_wdata_i[3:0];
        les_pkg::CfgClusterSize:   cfg_q.cluster_size    <= cfg_wdata_i;
        les_pkg::CfgRemotePeers:   cfg_q.remote_peers    <= cfg_wdata_i[3:0];
        les_pkg::CfgStartAsLeader: cfg_q.start_as_leader <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      ev_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ev_q.mode      <= mode_i;
      ev_q.msg_term  <= msg_term_i;
      ev_q.from_node <= from_node_i;
      ev_q.cand_lsn  <= cand_lsn_i;
      ev_q.local_lsn <= local_lsn_i;
      ev_q.granted   <= granted_i;
    end
  end

  les_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .ev_i    (ev_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // node state commits when the request moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.node_role         <= les_pkg::RoleFollower;
      state_q.term              <= 64'd0;
      state_q.vote_holder       <= 4'd0;
      state_q.vote_holder_valid <= 1'b0;
      state_q.leader            <= 4'd0;
      state_q.leader_valid      <= 1'b0;
      state_q.vote_count        <= 5'd0;
      out_valid_q               <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ev_valid_q;
      if (ev_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ev_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign role_o                = res_q.role;
  assign term_now_o            = res_q.term_now;
  assign leader_idx_o          = res_q.leader_idx;
  assign leader_known_o        = res_q.leader_known;
  assign vote_granted_o        = res_q.vote_granted;
  assign became_leader_o       = res_q.became_leader;
  assign stepped_down_o        = res_q.stepped_down;
  assign persist_write_o       = res_q.persist_write;
  assign persist_voted_id_o    = res_q.persist_voted_id;
  assign persist_voted_valid_o = res_q.persist_voted_valid;
  assign send_heartbeat_o      = res_q.send_heartbeat;
  assign send_vote_req_o       = res_q.send_vote_req;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for leader_election_step_core: random and directed event
// requests, an in-bench election tracker predicts every result in order.
// Depends on les_pkg and the core RTL only.

class election_mirror;
  // tracked node state and configuration
  les_pkg::role_e role_q;
  logic [63:0]    term_q;
  logic [3:0]     vote_target;
  bit             voted_valid;
  logic [3:0]     leader_q;
  bit             leader_valid;
  logic [4:0]     votes;
  les_pkg::cfg_t  cfg;

  les_pkg::result_t owed_outcomes[$];
  int unsigned      mismatches;

  function new();
    cfg = '{self_id: 4'd0, cluster_size: 5'd1, remote_peers: 4'd0, start_as_leader: 1'b0};
    role_q = les_pkg::RoleFollower;
    term_q = '0;
    vote_target = '0;
    voted_valid = 1'b0;
    leader_q = '0;
    leader_valid = 1'b0;
    votes = '0;
    mismatches = 0;
  endfunction

  function void set_register(les_pkg::cfg_idx_e idx, logic [4:0] val);
    case (idx)
      les_pkg::CfgSelfId:        cfg.self_id = val[3:0];
      les_pkg::CfgClusterSize:   cfg.cluster_size = val;
      les_pkg::CfgRemotePeers:   cfg.remote_peers = val[3:0];
      les_pkg::CfgStartAsLeader: cfg.start_as_leader = val[0];
      default: ;
    endcase
  endfunction

  function int quorum_size();
    int n;
    n = cfg.cluster_size;
    if (n == 0) n = 1;
    if (n > les_pkg::MaxNodes) n = les_pkg::MaxNodes;
    return (n + 1) / 2;
  endfunction

  // returns the heartbeat broadcast command
  function bit take_leadership();
    role_q = les_pkg::RoleLeader;
    leader_q = cfg.self_id;
    leader_valid = 1'b1;
    votes = '0;
    return cfg.remote_peers != 0;
  endfunction

  function void note_event(les_pkg::event_t ev);
    les_pkg::result_t r;
    logic [3:0]       self;
    r = '0;
    self = cfg.self_id;
    case (ev.mode)
      les_pkg::ModeHeartbeat: begin
        if (ev.msg_term >= term_q) begin
          if (ev.msg_term > term_q) begin
            term_q = ev.msg_term;
            voted_valid = 1'b0;
            vote_target = '0;
            r.persist_write = 1'b1;
            if (role_q != les_pkg::RoleFollower) begin
              role_q = les_pkg::RoleFollower;
              r.stepped_down = 1'b1;
            end
            leader_q = ev.from_node;
            leader_valid = 1'b1;
          end else if (role_q == les_pkg::RoleCandidate) begin
            role_q = les_pkg::RoleFollower;
            r.stepped_down = 1'b1;
            leader_q = ev.from_node;
            leader_valid = 1'b1;
          end else if (role_q == les_pkg::RoleFollower) begin
            leader_q = ev.from_node;
            leader_valid = 1'b1;
          end else if (ev.from_node != self) begin
            // rival leader at our own term
            role_q = les_pkg::RoleFollower;
            r.stepped_down = 1'b1;
            leader_q = ev.from_node;
            leader_valid = 1'b1;
            if (term_q != 0) r.persist_write = 1'b1;
          end
        end
      end
      les_pkg::ModeVoteReq: begin
        if (ev.msg_term > term_q) begin
          term_q = ev.msg_term;
          voted_valid = 1'b0;
          vote_target = '0;
          if (role_q != les_pkg::RoleFollower) begin
            role_q = les_pkg::RoleFollower;
            r.stepped_down = 1'b1;
          end
        end
        if (ev.msg_term >= term_q && ev.cand_lsn >= ev.local_lsn &&
            (!voted_valid || vote_target == ev.from_node)) begin
          r.vote_granted = 1'b1;
          vote_target = ev.from_node;
          voted_valid = 1'b1;
          r.persist_write = 1'b1;
          r.persist_voted_id = ev.from_node;
          r.persist_voted_valid = 1'b1;
        end
      end
      les_pkg::ModeVoteResp: begin
        if (ev.msg_term > term_q) begin
          term_q = ev.msg_term;
          voted_valid = 1'b0;
          vote_target = '0;
          role_q = les_pkg::RoleFollower;
          leader_valid = 1'b0;
          leader_q = '0;
        end
        if (role_q == les_pkg::RoleCandidate && ev.msg_term >= term_q && ev.granted) begin
          if (votes < les_pkg::CountMax) votes++;
          if (votes >= quorum_size()) begin
            r.send_heartbeat = take_leadership();
            r.became_leader = 1'b1;
          end
        end
      end
      les_pkg::ModeTimeout: begin
        if (role_q == les_pkg::RoleLeader) begin
          r.send_heartbeat = cfg.remote_peers != 0;
        end else begin
          if (term_q != '1) term_q++;
          vote_target = self;
          voted_valid = 1'b1;
          votes = 5'd1;
          role_q = les_pkg::RoleCandidate;
          r.persist_write = 1'b1;
          r.persist_voted_id = self;
          r.persist_voted_valid = 1'b1;
          r.send_vote_req = cfg.remote_peers != 0;
          if (1 >= quorum_size()) begin
            r.send_heartbeat = take_leadership();
            r.became_leader = 1'b1;
          end
        end
      end
      les_pkg::ModeStart: begin
        if (cfg.start_as_leader) begin
          role_q = les_pkg::RoleLeader;
          if (term_q == 0) term_q = 64'd1;
          leader_q = self;
          leader_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.role = role_q;
    r.term_now = term_q;
    r.leader_idx = leader_valid ? leader_q : 4'd0;
    r.leader_known = leader_valid;
    owed_outcomes.insert(owed_outcomes.size(), r);
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_outcome(les_pkg::result_t got);
    les_pkg::result_t want;
    if (owed_outcomes.size() == 0) begin
      $error("result with no request outstanding");
      mismatches++;
      return;
    end
    want = owed_outcomes.pop_front();
    check_field("role", 64'(want.role), 64'(got.role));
    check_field("term_now", want.term_now, got.term_now);
    check_field("leader_idx", 64'(want.leader_idx), 64'(got.leader_idx));
    check_field("leader_known", 64'(want.leader_known), 64'(got.leader_known));
    check_field("vote_granted", 64'(want.vote_granted), 64'(got.vote_granted));
    check_field("became_leader", 64'(want.became_leader), 64'(got.became_leader));
    check_field("stepped_down", 64'(want.stepped_down), 64'(got.stepped_down));
    check_field("persist_write", 64'(want.persist_write), 64'(got.persist_write));
    check_field("persist_voted_id", 64'(want.persist_voted_id), 64'(got.persist_voted_id));
    check_field("persist_voted_valid", 64'(want.persist_voted_valid),
                64'(got.persist_voted_valid));
    check_field("send_heartbeat", 64'(want.send_heartbeat), 64'(got.send_heartbeat));
    check_field("send_vote_req", 64'(want.send_vote_req), 64'(got.send_vote_req));
  endfunction
endclass

module tb;

  localparam int          StallLimit   = 1000;  // cycles with no handshake at all
  localparam int          HoldOff      = 60;    // long receiver stall, in cycles
  localparam int          ItemsPerStep = 212;   // random requests per config step
  localparam logic [2:0]  ModeLastCode = 3'd7;  // highest encodable mode
  localparam logic [63:0] TermMax      = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [4:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  mode_i;
  logic [63:0] msg_term_i;
  logic [3:0]  from_node_i;
  logic [63:0] cand_lsn_i;
  logic [63:0] local_lsn_i;
  logic        granted_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  role_o;
  logic [63:0] term_now_o;
  logic [3:0]  leader_idx_o;
  logic        leader_known_o;
  logic        vote_granted_o;
  logic        became_leader_o;
  logic        stepped_down_o;
  logic        persist_write_o;
  logic [3:0]  persist_voted_id_o;
  logic        persist_voted_valid_o;
  logic        send_heartbeat_o;
  logic        send_vote_req_o;

  election_mirror board;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          stall_cycles;

  leader_election_step_core u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_addr_i            (cfg_addr_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .mode_i                (mode_i),
    .msg_term_i            (msg_term_i),
    .from_node_i           (from_node_i),
    .cand_lsn_i            (cand_lsn_i),
    .local_lsn_i           (local_lsn_i),
    .granted_i             (granted_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .role_o                (role_o),
    .term_now_o            (term_now_o),
    .leader_idx_o          (leader_idx_o),
    .leader_known_o        (leader_known_o),
    .vote_granted_o        (vote_granted_o),
    .became_leader_o       (became_leader_o),
    .stepped_down_o        (stepped_down_o),
    .persist_write_o       (persist_write_o),
    .persist_voted_id_o    (persist_voted_id_o),
    .persist_voted_valid_o (persist_voted_valid_o),
    .send_heartbeat_o      (send_heartbeat_o),
    .send_vote_req_o       (send_vote_req_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic les_pkg::event_t make_event(logic [2:0] m, logic [63:0] term,
                                                 logic [3:0] from, logic [63:0] cand,
                                                 logic [63:0] loc, logic g);
    les_pkg::event_t ev;
    ev.mode = m;
    ev.msg_term = term;
    ev.from_node = from;
    ev.cand_lsn = cand;
    ev.local_lsn = loc;
    ev.granted = g;
    return ev;
  endfunction

  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed traffic around the tracked term: elections, answers
  // to our own vote requests, heartbeats from a leader, rival candidates.
  // The rest is stale or garbage requests and unused mode codes.
  function automatic les_pkg::event_t random_event();
    les_pkg::event_t ev;
    int              pick;
    logic [63:0]     now;
    logic [63:0]     stale;
    now = board.term_q;
    stale = (now == 0) ? 64'd0 : now - 64'd1;
    pick = $urandom_range(99);
    ev.from_node = ($urandom_range(3) == 0) ? board.cfg.self_id : 4'($urandom_range(15));
    ev.cand_lsn = ($urandom_range(9) == 0) ? wide_random() : 64'($urandom_range(20));
    ev.local_lsn = ($urandom_range(9) == 0) ? wide_random() : 64'($urandom_range(16));
    ev.granted = ($urandom_range(99) < 85);
    ev.msg_term = now;
    if (pick < 12) begin
      ev.mode = les_pkg::ModeTimeout;
    end else if (pick < 16) begin
      ev.mode = les_pkg::ModeStart;
    end else if (pick < 42) begin
      ev.mode = les_pkg::ModeVoteResp;
      case ($urandom_range(9))
        0: ev.msg_term = stale;
        1: ev.msg_term = now + 64'd1;
        default: ev.msg_term = now;
      endcase
    end else if (pick < 64) begin
      ev.mode = les_pkg::ModeHeartbeat;
      ev.msg_term = ($urandom_range(4) == 0) ? now + 64'd1 : now;
      if ($urandom_range(9) == 0) ev.msg_term = stale;
    end else if (pick < 84) begin
      ev.mode = les_pkg::ModeVoteReq;
      ev.msg_term = ($urandom_range(2) == 0) ? now : now + 64'd1;
    end else if (pick < 88) begin
      ev.mode = 3'(les_pkg::ModeStart) + 3'($urandom_range(1, 3));
    end else begin
      ev.mode = 3'($urandom_range(7));
      ev.msg_term = wide_random();
      ev.cand_lsn = wide_random();
      ev.local_lsn = wide_random();
    end
    return ev;
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_request(les_pkg::event_t ev);
    in_valid_i = 1'b1;
    mode_i = ev.mode;
    msg_term_i = ev.msg_term;
    from_node_i = ev.from_node;
    cand_lsn_i = ev.cand_lsn;
    local_lsn_i = ev.local_lsn;
    granted_i = ev.granted;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_event(ev);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  // Drain every outstanding request so the block is idle for a register write.
  task automatic settle();
    in_valid_i = 1'b0;
    while (board.owed_outcomes.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(les_pkg::cfg_idx_e idx, logic [4:0] val);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.set_register(idx, val);
  endtask

  task automatic load_config(logic [3:0] self, logic [4:0] size, logic [3:0] peers, logic lead);
    write_reg(les_pkg::CfgSelfId, 5'(self));
    write_reg(les_pkg::CfgClusterSize, size);
    write_reg(les_pkg::CfgRemotePeers, 5'(peers));
    write_reg(les_pkg::CfgStartAsLeader, 5'(lead));
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // request register fills and in_ready_o drops while the sender keeps going.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldOff) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : collect
    les_pkg::result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.role = les_pkg::role_e'(role_o);
      got.term_now = term_now_o;
      got.leader_idx = leader_idx_o;
      got.leader_known = leader_known_o;
      got.vote_granted = vote_granted_o;
      got.became_leader = became_leader_o;
      got.stepped_down = stepped_down_o;
      got.persist_write = persist_write_o;
      got.persist_voted_id = persist_voted_id_o;
      got.persist_voted_valid = persist_voted_valid_o;
      got.send_heartbeat = send_heartbeat_o;
      got.send_vote_req = send_vote_req_o;
      board.check_outcome(got);
    end
  end

  // Watchdog: any handshake on either side resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin
    int m;
    int phase;
    int step;
    board = new();
    stall_cycles = 0;
    hold_req = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 51;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = les_pkg::CfgSelfId;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = les_pkg::ModeHeartbeat;
    msg_term_i = '0;
    from_node_i = '0;
    cand_lsn_i = '0;
    local_lsn_i = '0;
    granted_i = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // --- directed: reset config (self 0, one node, no peers, no auto-lead)
    send_request(make_event(les_pkg::ModeStart, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0)); // no effect
    for (m = 32'(les_pkg::ModeStart) + 1; m <= 32'(ModeLastCode); m++) begin // unused codes
      send_request(make_event(3'(m), wide_random(), 4'hF, TermMax, 64'd0, 1'b1));
    end
    send_request(make_event(les_pkg::ModeHeartbeat, 64'd0, 4'd7, 64'd0, 64'd0, 1'b0));
    // not candidate
    send_request(make_event(les_pkg::ModeVoteResp, 64'd0, 4'd7, 64'd0, 64'd0, 1'b1));

    settle();
    write_reg(les_pkg::CfgStartAsLeader, 5'd1);
    write_reg(les_pkg::CfgRemotePeers, 5'd2);
    // term 0 -> 1, then leader beats, own echo, rival leader, quorum of one
    send_request(make_event(les_pkg::ModeStart, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeTimeout, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeHeartbeat, 64'd1, 4'd0, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeHeartbeat, 64'd1, 4'd9, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeTimeout, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0));
    // voted for self, log behind, grant, already voted
    send_request(make_event(les_pkg::ModeVoteReq, 64'd2, 4'd3, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeVoteReq, 64'd3, 4'd3, 64'd0, TermMax, 1'b0));
    send_request(make_event(les_pkg::ModeVoteReq, 64'd3, 4'd3, TermMax, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeVoteReq, 64'd3, 4'd4, TermMax, 64'd0, 1'b0));

    settle();
    write_reg(les_pkg::CfgClusterSize, 5'd5);                                  // quorum 3
    send_request(make_event(les_pkg::ModeTimeout, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0));
    // refused, stale term, counted
    send_request(make_event(les_pkg::ModeVoteResp, 64'd4, 4'd1, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeVoteResp, 64'd3, 4'd1, 64'd0, 64'd0, 1'b1));
    send_request(make_event(les_pkg::ModeVoteResp, 64'd4, 4'd1, 64'd0, 64'd0, 1'b1));
    // lost race
    send_request(make_event(les_pkg::ModeHeartbeat, 64'd4, 4'd6, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeTimeout, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeVoteResp, 64'd5, 4'd1, 64'd0, 64'd0, 1'b1));
    // wins, then a newer term
    send_request(make_event(les_pkg::ModeVoteResp, 64'd5, 4'd2, 64'd0, 64'd0, 1'b1));
    send_request(make_event(les_pkg::ModeVoteResp, 64'd9, 4'd2, 64'd0, 64'd0, 1'b0));

    // --- random: three idling patterns, three register settings each
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 23; recv_idle_pct = 51; end
        1: begin send_idle_pct = 51; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (step = 0; step < 3; step++) begin
        settle();
        case (phase * 3 + step)
          0: load_config(4'd15, 5'd16, 4'd15, 1'b1);
          1: load_config(4'd0, 5'd0, 4'd0, 1'b0);
          2: load_config(4'd7, 5'd31, 4'd1, 1'b1);
          4: load_config(4'd10, 5'd17, 4'd0, 1'b0);
          default: load_config(4'($urandom_range(15)), 5'($urandom_range(1, 7)),
                               4'($urandom_range(15)), 1'($urandom_range(1)));
        endcase
        if (phase == 2 && step == 0) hold_req = 1'b1;
        repeat (ItemsPerStep) send_request(random_event());
      end
    end

    // --- directed tail: terms at the top of the range
    settle();
    load_config(4'd2, 5'd1, 4'd3, 1'b0);
    send_request(make_event(les_pkg::ModeVoteReq, TermMax, 4'd5, TermMax, TermMax, 1'b0));
    // term pinned
    send_request(make_event(les_pkg::ModeTimeout, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeHeartbeat, TermMax, 4'd1, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeTimeout, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0));
    send_request(make_event(les_pkg::ModeStart, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0));

    in_valid_i = 1'b0;
    while (board.owed_outcomes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (board.mismatches == 0 && board.owed_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
